@@ hdl/jha_pkg.sv @@
// jha_pkg: shared sizes, request and register codes, and item types of the
// joint histogram accumulator. No dependencies.
`default_nettype none

package jha_pkg;

    localparam int MAX_BINS        = 4096;
    localparam int ADDR_BITS       = $clog2(MAX_BINS);
    localparam int SAMPLE_BITS     = 16;
    localparam int COUNT_BITS      = 32;
    localparam int SIZE_BITS       = 16;
    localparam int NBINS_BITS      = 13;
    localparam int DIFF_BITS       = SAMPLE_BITS + 1;
    localparam int PROD_BITS       = 2 * NBINS_BITS;
    localparam int OFFSET_BITS     = PROD_BITS + 1;
    localparam int DIV_STEPS       = SAMPLE_BITS;
    localparam int STEP_BITS       = $clog2(DIV_STEPS + 1);
    localparam int OUT_COUNT_BITS  = 32;
    localparam int OUT_OFFSET_BITS = 12;
    localparam int INDEX_BITS      = 12;
    localparam int CFG_INDEX_BITS  = 4;
    localparam int CFG_DATA_BITS   = 16;
    localparam int EXCL_BITS       = 2;

    // request codes
    localparam logic [1:0] REQ_ACCUM  = 2'd0;
    localparam logic [1:0] REQ_LOOKUP = 2'd1;
    localparam logic [1:0] REQ_READ   = 2'd2;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LOWER_A    = 4'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BIN_SIZE_A = 4'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BINS_A     = 4'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LOWER_B    = 4'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BIN_SIZE_B = 4'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BINS_B     = 4'd5;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_EXCLUDE    = 4'd6;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_JOINT      = 4'd7;

    typedef struct packed {
        logic [1:0]                    req_type;
        logic signed [SAMPLE_BITS-1:0] sample_a;
        logic signed [SAMPLE_BITS-1:0] sample_b;
        logic                          mask_bit;
        logic [INDEX_BITS-1:0]         bin_index;
        logic                          clear_after;
    } jha_in_t;

    typedef struct packed {
        logic [OUT_COUNT_BITS-1:0]  bin_count;
        logic [OUT_OFFSET_BITS-1:0] bin_offset;
        logic                       included;
        logic                       offset_overflow;
    } jha_out_t;

    typedef struct packed {
        logic                   done;
        logic [SAMPLE_BITS-1:0] quotient;
    } jha_div_res_t;

endpackage

`default_nettype wire

@@ hdl/jha_ram.sv @@
// jha_ram: generic single-port synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module jha_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    addr,
    input  wire logic [WIDTH-1:0] wdata,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ hdl/jha_div.sv @@
// jha_div: restoring divider, one quotient bit per cycle, for the bin index.
// Depends on jha_pkg.
`default_nettype none

module jha_div (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                start,
    input  wire logic [jha_pkg::SAMPLE_BITS-1:0]     dividend,
    input  wire logic [jha_pkg::SIZE_BITS-1:0]       divisor,
    output jha_pkg::jha_div_res_t                    res
);

    logic [jha_pkg::SIZE_BITS-1:0]   rem_reg, rem_next;
    logic [jha_pkg::SAMPLE_BITS-1:0] quo_reg, quo_next;
    logic [jha_pkg::SIZE_BITS-1:0]   dsr_reg, dsr_next;
    logic [jha_pkg::STEP_BITS-1:0]   cnt_reg, cnt_next;
    logic                            done_reg, done_next;
    logic [jha_pkg::SIZE_BITS:0]     trial;
    logic [jha_pkg::SIZE_BITS:0]     trial_sub;
    logic                            fits;

    assign trial     = {rem_reg, quo_reg[jha_pkg::SAMPLE_BITS-1]};
    assign fits      = trial >= {1'b0, dsr_reg};
    assign trial_sub = trial - {1'b0, dsr_reg};

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next = '0;
            quo_next = dividend;
            dsr_next = divisor;
            cnt_next = jha_pkg::STEP_BITS'(jha_pkg::DIV_STEPS);
        end else if (cnt_reg != '0) begin
            // remainder stays below the divisor, so the top bit drops
            rem_next  = fits ? trial_sub[jha_pkg::SIZE_BITS-1:0]
                             : trial[jha_pkg::SIZE_BITS-1:0];
            quo_next  = {quo_reg[jha_pkg::SAMPLE_BITS-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == jha_pkg::STEP_BITS'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign res.done     = done_reg;
    assign res.quotient = quo_reg;

endmodule

`default_nettype wire

@@ hdl/joint_histogram_accumulator.sv @@
// joint_histogram_accumulator: top level of the histogram engine.
// Depends on jha_pkg, jha_div and jha_ram.
//
//  channel   direction  handshake            payload
//  s_        in         s_valid / s_ready    s_data   (jha_in_t)
//  m_        out        m_valid / m_ready    m_data   (jha_out_t)
//  cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Flow: one item at a time. Requests 0 and 1 pass through start, divide,
// multiply, read and update, the divide set by the 16-step shared-width divider
// (one per dimension, run side by side); requests 2 and 3 take memory read, update.
// The next item is taken the cycle after the result is loaded.
// Reset: the count memory is swept to zero, one entry per cycle, over all
// MAX_BINS (4096) entries after reset; s_ready stays low meanwhile.
// Stalls: a finished result waits in the output register; the next item is
// accepted and worked on, and only its final update step holds for m_ready.
`default_nettype none

module joint_histogram_accumulator (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire jha_pkg::jha_in_t                       s_data,
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output jha_pkg::jha_out_t                           m_data,
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [jha_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  wire logic [jha_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_START = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_MUL   = 3'd4;
    localparam logic [2:0] ST_READ  = 3'd5;
    localparam logic [2:0] ST_RMW   = 3'd6;

    localparam int SB = jha_pkg::SAMPLE_BITS;
    localparam int NB = jha_pkg::NBINS_BITS;
    localparam int OB = jha_pkg::OFFSET_BITS;
    localparam int AB = jha_pkg::ADDR_BITS;
    localparam int CB = jha_pkg::COUNT_BITS;

    // ---------------- configuration registers ----------------
    logic [SB-1:0]                    lower_a_reg, lower_b_reg;
    logic [jha_pkg::SIZE_BITS-1:0]    bin_size_a_reg, bin_size_b_reg;
    logic [NB-1:0]                    bins_a_reg, bins_b_reg;
    logic [jha_pkg::EXCL_BITS-1:0]    exclude_reg;
    logic                             joint_reg;

    assign cfg_ready = 1'b1;

    // Take a write whenever offered; unknown indexes are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lower_a_reg    <= '0;
            bin_size_a_reg <= jha_pkg::SIZE_BITS'(1);
            bins_a_reg     <= NB'(256);
            lower_b_reg    <= '0;
            bin_size_b_reg <= jha_pkg::SIZE_BITS'(1);
            bins_b_reg     <= NB'(1);
            exclude_reg    <= '0;
            joint_reg      <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                jha_pkg::CFG_LOWER_A:    lower_a_reg    <= cfg_data[SB-1:0];
                jha_pkg::CFG_BIN_SIZE_A: bin_size_a_reg <= cfg_data[jha_pkg::SIZE_BITS-1:0];
                jha_pkg::CFG_BINS_A:     bins_a_reg     <= cfg_data[NB-1:0];
                jha_pkg::CFG_LOWER_B:    lower_b_reg    <= cfg_data[SB-1:0];
                jha_pkg::CFG_BIN_SIZE_B: bin_size_b_reg <= cfg_data[jha_pkg::SIZE_BITS-1:0];
                jha_pkg::CFG_BINS_B:     bins_b_reg     <= cfg_data[NB-1:0];
                jha_pkg::CFG_EXCLUDE:    exclude_reg    <= cfg_data[jha_pkg::EXCL_BITS-1:0];
                jha_pkg::CFG_JOINT:      joint_reg      <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // A zero bin size or zero bin count behaves as one.
    logic [jha_pkg::SIZE_BITS-1:0] size_a_eff, size_b_eff;
    logic [NB-1:0]                 nbins_a, nbins_b;

    assign size_a_eff = (bin_size_a_reg == '0) ? jha_pkg::SIZE_BITS'(1) : bin_size_a_reg;
    assign size_b_eff = (bin_size_b_reg == '0) ? jha_pkg::SIZE_BITS'(1) : bin_size_b_reg;
    assign nbins_a    = (bins_a_reg == '0) ? NB'(1) : bins_a_reg;
    assign nbins_b    = (bins_b_reg == '0) ? NB'(1) : bins_b_reg;

    // Clamp a quotient into [0, n-1]; top bit of the result flags clamping.
    function automatic logic [NB:0] clamp_bin(input logic neg,
                                             input logic [SB-1:0] q,
                                             input logic [NB-1:0] n);
        logic [NB:0] r;
        if (neg) begin
            r = {1'b1, {NB{1'b0}}};
        end else if (q >= SB'(n)) begin
            r = {1'b1, n - 1'b1};
        end else begin
            r = {1'b0, q[NB-1:0]};
        end
        return r;
    endfunction

    // ---------------- control and item registers ----------------
    logic [2:0]              state_reg, state_next;
    logic [AB-1:0]           clr_addr_reg, clr_addr_next;
    jha_pkg::jha_in_t        item_reg, item_next;
    logic                    neg_a_reg, neg_a_next, neg_b_reg, neg_b_next;
    logic [NB-1:0]           ba_reg, ba_next, bb_reg, bb_next;
    logic                    oor_a_reg, oor_a_next, oor_b_reg, oor_b_next;
    logic [OB-1:0]           offset_reg, offset_next;
    logic                    incl_reg, incl_next;
    logic                    m_valid_reg, m_valid_next;
    jha_pkg::jha_out_t       out_reg, out_next;

    // ---------------- datapath ----------------
    logic [jha_pkg::DIFF_BITS-1:0] diff_a, diff_b;
    jha_pkg::jha_div_res_t         div_a, div_b;
    logic                          div_start;
    logic [jha_pkg::PROD_BITS-1:0] prod;
    logic                          drop;
    logic                          ovf, hit, out_free;
    logic [CB-1:0]                 ram_rdata, ram_wdata, count_inc, count_out;
    logic [AB-1:0]                 ram_addr;
    logic                          ram_we;

    // Sample minus lower bound, one bit wider so it never wraps.
    assign diff_a = {item_reg.sample_a[SB-1], item_reg.sample_a}
                  - {lower_a_reg[SB-1], lower_a_reg};
    assign diff_b = {item_reg.sample_b[SB-1], item_reg.sample_b}
                  - {lower_b_reg[SB-1], lower_b_reg};

    jha_div u_div_a (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (diff_a[SB-1:0]),
        .divisor  (size_a_eff),
        .res      (div_a)
    );

    jha_div u_div_b (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (diff_b[SB-1:0]),
        .divisor  (size_b_eff),
        .res      (div_b)
    );

    assign prod = jha_pkg::PROD_BITS'(nbins_a) * jha_pkg::PROD_BITS'(bb_reg);

    assign drop = (oor_a_reg & exclude_reg[0])
                | (joint_reg & oor_b_reg & exclude_reg[1])
                | ((item_reg.req_type == jha_pkg::REQ_ACCUM) & ~item_reg.mask_bit);

    assign ovf       = offset_reg >= OB'(jha_pkg::MAX_BINS);
    assign hit       = incl_reg & ~ovf;
    assign out_free  = ~m_valid_reg | m_ready;
    assign count_inc = (ram_rdata == '1) ? ram_rdata : ram_rdata + 1'b1;
    assign ram_addr  = (state_reg == ST_CLEAR) ? clr_addr_reg : offset_reg[AB-1:0];

    jha_ram #(
        .WIDTH (CB),
        .DEPTH (jha_pkg::MAX_BINS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        item_next     = item_reg;
        neg_a_next    = neg_a_reg;
        neg_b_next    = neg_b_reg;
        ba_next       = ba_reg;
        bb_next       = bb_reg;
        oor_a_next    = oor_a_reg;
        oor_b_next    = oor_b_reg;
        offset_next   = offset_reg;
        incl_next     = incl_reg;
        m_valid_next  = m_valid_reg & ~m_ready;
        out_next      = out_reg;
        ram_we        = 1'b0;
        ram_wdata     = '0;
        div_start     = 1'b0;
        count_out     = '0;

        unique case (state_reg)
            ST_CLEAR: begin
                // zero one entry per cycle
                ram_we        = 1'b1;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == AB'(jha_pkg::MAX_BINS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    item_next = s_data;
                    priority if (s_data.req_type == jha_pkg::REQ_ACCUM ||
                                 s_data.req_type == jha_pkg::REQ_LOOKUP) begin
                        state_next = ST_START;
                    end else if (s_data.req_type == jha_pkg::REQ_READ) begin
                        offset_next = OB'(s_data.bin_index);
                        incl_next   = 1'b1;
                        state_next  = ST_READ;
                    end else begin
                        // unknown request: all-zero result, no memory change
                        offset_next = '0;
                        incl_next   = 1'b0;
                        state_next  = ST_READ;
                    end
                end
            end
            ST_START: begin
                div_start  = 1'b1;
                neg_a_next = diff_a[jha_pkg::DIFF_BITS-1];
                neg_b_next = diff_b[jha_pkg::DIFF_BITS-1];
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_a.done) begin
                    {oor_a_next, ba_next} = clamp_bin(neg_a_reg, div_a.quotient, nbins_a);
                    {oor_b_next, bb_next} = clamp_bin(neg_b_reg, div_b.quotient, nbins_b);
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                offset_next = joint_reg ? OB'(ba_reg) + OB'(prod) : OB'(ba_reg);
                incl_next   = ~drop;
                state_next  = ST_READ;
            end
            ST_READ: begin
                state_next = ST_RMW;
            end
            ST_RMW: begin
                // read data holds while stalled: the address does not move
                if (out_free) begin
                    unique case (item_reg.req_type)
                        jha_pkg::REQ_ACCUM: begin
                            count_out = hit ? count_inc : '0;
                            ram_we    = hit;
                            ram_wdata = count_inc;
                        end
                        jha_pkg::REQ_READ: begin
                            count_out = hit ? ram_rdata : '0;
                            ram_we    = hit & item_reg.clear_after;
                        end
                        default: begin
                            count_out = hit ? ram_rdata : '0;
                        end
                    endcase
                    out_next.bin_count       = jha_pkg::OUT_COUNT_BITS'(count_out);
                    out_next.bin_offset      = offset_reg[jha_pkg::OUT_OFFSET_BITS-1:0];
                    out_next.included        = (item_reg.req_type == jha_pkg::REQ_READ)
                                             ? ~ovf : incl_reg;
                    out_next.offset_overflow = ovf;
                    m_valid_next             = 1'b1;
                    state_next               = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            m_valid_reg  <= m_valid_next;
        end
        item_reg   <= item_next;
        neg_a_reg  <= neg_a_next;
        neg_b_reg  <= neg_b_next;
        ba_reg     <= ba_next;
        bb_reg     <= bb_next;
        oor_a_reg  <= oor_a_next;
        oor_b_reg  <= oor_b_next;
        offset_reg <= offset_next;
        incl_reg   <= incl_next;
        out_reg    <= out_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // ---------------- assertions ----------------
    // both dividers start together and must finish together
    a_div_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        div_a.done == div_b.done)
        else $error("divider lanes out of step");

    // the memory is written only by the clearing sweep or the update step
    a_ram_write_state: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == ST_CLEAR || state_reg == ST_RMW))
        else $error("memory written outside clear or update");

    // a result appears only after an update step
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_RMW)
        else $error("result loaded outside update step");

    // an offset beyond the store never reports a count
    a_overflow_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_reg.offset_overflow) |-> out_reg.bin_count == '0)
        else $error("count reported for overflowed offset");

endmodule

`default_nettype wire
